// File: rtl/pacs_pkg.sv
// pacs_pkg: shared types and codes for the parallel converter capture sequencer
// no dependencies; used by the interfaces, the register block, the sequencer and the top level
`default_nettype none

package pacs_pkg;

  localparam int unsigned BusBits = 16;
  localparam int unsigned CountBits = 16;
  localparam int unsigned TimerBits = 8;
  localparam int unsigned IndexBits = 3;
  localparam int unsigned MaskBits = 8;
  localparam int unsigned AddrBits = 5;
  localparam int unsigned DataBits = 32;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_SPARE = 2'd3
  } command_t;

  // register indexes, byte address is 4x this
  typedef enum logic [2:0] {
    REG_CHANNEL_MASK = 3'd0,
    REG_RANGE_HIGH   = 3'd1,
    REG_OVERSAMPLE   = 3'd2,
    REG_PULSE        = 3'd3,
    REG_SETTLE       = 3'd4,
    REG_RESET        = 3'd5,
    REG_SPARE6       = 3'd6,
    REG_SPARE7       = 3'd7
  } reg_index_t;

  localparam logic [2:0] OversampleBad = 3'd7;

  typedef struct packed {
    logic [MaskBits-1:0]  channel_mask;
    logic                 range_high;
    logic [2:0]           oversample_ratio;
    logic [TimerBits-1:0] pulse_cycles;
    logic [TimerBits-1:0] settle_cycles;
    logic [TimerBits-1:0] reset_cycles;
  } cfg_t;

  typedef struct packed {
    logic                 convst_a_pin;
    logic                 convst_b_pin;
    logic                 read_select_pin;
    logic                 reset_pin;
    logic                 range_pin;
    logic [2:0]           oversample_pins;
    logic                 sample_valid;
    logic [BusBits-1:0]   sample_value;
    logic [IndexBits-1:0] sample_channel;
    logic                 collecting;
    logic                 overrun_flag;
    logic                 run_done;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/pacs_if.sv
// pacs_in_if / pacs_out_if: valid-ready channels for pin words and result words
// depends on pacs_pkg for field widths
`default_nettype none

interface pacs_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        command;
  logic [pacs_pkg::CountBits-1:0]    sample_count;
  logic                              busy_pin;
  logic [pacs_pkg::BusBits-1:0]      data_bus;

  modport source (output valid, command, sample_count, busy_pin, data_bus, input ready);
  modport sink (input valid, command, sample_count, busy_pin, data_bus, output ready);
endinterface

interface pacs_out_if;
  logic                              valid;
  logic                              ready;
  logic                              convst_a_pin;
  logic                              convst_b_pin;
  logic                              read_select_pin;
  logic                              reset_pin;
  logic                              range_pin;
  logic [2:0]                        oversample_pins;
  logic                              sample_valid;
  logic [pacs_pkg::BusBits-1:0]      sample_value;
  logic [pacs_pkg::IndexBits-1:0]    sample_channel;
  logic                              collecting;
  logic                              overrun_flag;
  logic                              run_done;

  modport source (
    output valid, convst_a_pin, convst_b_pin, read_select_pin, reset_pin, range_pin,
           oversample_pins, sample_valid, sample_value, sample_channel, collecting,
           overrun_flag, run_done,
    input  ready
  );
  modport sink (
    input  valid, convst_a_pin, convst_b_pin, read_select_pin, reset_pin, range_pin,
           oversample_pins, sample_valid, sample_value, sample_channel, collecting,
           overrun_flag, run_done,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/pacs_cfg.sv
// pacs_cfg: APB-style configuration registers of the capture sequencer
// depends on pacs_pkg for register indexes and the cfg_t bundle
`default_nettype none

module pacs_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pacs_pkg::AddrBits-1:0] paddr,
  input  wire logic [pacs_pkg::DataBits-1:0] pwdata,
  output logic      [pacs_pkg::DataBits-1:0] prdata,
  output logic                               pready,
  output pacs_pkg::cfg_t                     cfg
);

  pacs_pkg::reg_index_t reg_index;
  logic                 wr_en;
  logic [7:0]           wr_byte;

  assign reg_index = pacs_pkg::reg_index_t'(paddr[pacs_pkg::AddrBits-1:2]);
  assign wr_en     = psel && penable && pwrite;
  assign wr_byte   = pwdata[7:0];
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_mask     <= 8'd1;
      cfg.range_high       <= 1'b0;
      cfg.oversample_ratio <= 3'd0;
      cfg.pulse_cycles     <= 8'd25;
      cfg.settle_cycles    <= 8'd50;
      cfg.reset_cycles     <= 8'd50;
    end else if (wr_en) begin
      unique case (reg_index)
        pacs_pkg::REG_CHANNEL_MASK: cfg.channel_mask <= wr_byte;
        pacs_pkg::REG_RANGE_HIGH:   cfg.range_high <= wr_byte[0];
        pacs_pkg::REG_OVERSAMPLE: begin
          // code seven is not a valid ratio, keep the old one
          if (wr_byte[2:0] != pacs_pkg::OversampleBad) begin
            cfg.oversample_ratio <= wr_byte[2:0];
          end
        end
        pacs_pkg::REG_PULSE:        cfg.pulse_cycles <= wr_byte;
        pacs_pkg::REG_SETTLE:       cfg.settle_cycles <= wr_byte;
        pacs_pkg::REG_RESET:        cfg.reset_cycles <= wr_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      pacs_pkg::REG_CHANNEL_MASK: prdata = {24'd0, cfg.channel_mask};
      pacs_pkg::REG_RANGE_HIGH:   prdata = {31'd0, cfg.range_high};
      pacs_pkg::REG_OVERSAMPLE:   prdata = {29'd0, cfg.oversample_ratio};
      pacs_pkg::REG_PULSE:        prdata = {24'd0, cfg.pulse_cycles};
      pacs_pkg::REG_SETTLE:       prdata = {24'd0, cfg.settle_cycles};
      pacs_pkg::REG_RESET:        prdata = {24'd0, cfg.reset_cycles};
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/pacs_seq.sv
// pacs_seq: per-clock phase sequencer with the result register
// depends on pacs_pkg for commands, cfg_t and result_t
`default_nettype none

module pacs_seq #(
  parameter int unsigned CHANNEL_COUNT = 8,
  parameter int unsigned SAMPLE_BITS   = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pacs_pkg::cfg_t                 cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     command,
  input  wire logic [pacs_pkg::CountBits-1:0] sample_count,
  input  wire logic                           busy_pin,
  input  wire logic [pacs_pkg::BusBits-1:0]   data_bus,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output pacs_pkg::result_t                   result
);

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_HI    = 4'd1,
    PH_RST_LO    = 4'd2,
    PH_CONV_A    = 4'd3,
    PH_CONV_B    = 4'd4,
    PH_SETTLE    = 4'd5,
    PH_WAIT_BUSY = 4'd6,
    PH_PAUSE     = 4'd7,
    PH_RD_LOW    = 4'd8,
    PH_RD_HIGH   = 4'd9
  } phase_t;

  localparam logic [pacs_pkg::IndexBits-1:0] LastIndex =
    pacs_pkg::IndexBits'(CHANNEL_COUNT - 1);
  localparam logic [pacs_pkg::BusBits-1:0] SampleMask =
    pacs_pkg::BusBits'((32'd1 << SAMPLE_BITS) - 32'd1);

  phase_t                           phase, phase_next, phase_cmd;
  logic [pacs_pkg::TimerBits-1:0]   phase_timer, phase_timer_next, timer_cmd;
  logic [pacs_pkg::TimerBits-1:0]   phase_len, phase_lim;
  logic [pacs_pkg::IndexBits-1:0]   read_index, read_index_next, index_cmd;
  logic [pacs_pkg::CountBits-1:0]   remaining_count, remaining_count_next, remain_cmd;
  logic                             overrun_seen, overrun_seen_next;
  logic                             accept, timed_done;
  pacs_pkg::command_t               cmd;
  pacs_pkg::result_t                result_next;

  assign cmd      = pacs_pkg::command_t'(command);
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // command takes effect before the pins are shown
  always_comb begin
    phase_cmd         = phase;
    timer_cmd         = phase_timer;
    index_cmd         = read_index;
    remain_cmd        = remaining_count;
    overrun_seen_next = overrun_seen;
    unique case (cmd)
      pacs_pkg::CMD_START: begin
        remain_cmd        = sample_count;
        overrun_seen_next = 1'b0;
        index_cmd         = '0;
        phase_cmd         = PH_RST_HI;
        timer_cmd         = '0;
      end
      pacs_pkg::CMD_TICK: begin
        if (phase >= PH_CONV_A && phase <= PH_RD_HIGH) begin
          overrun_seen_next = 1'b1;
        end else if (phase == PH_IDLE && remaining_count != '0) begin
          index_cmd = '0;
          phase_cmd = PH_CONV_A;
          timer_cmd = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (phase_cmd)
      PH_RST_HI, PH_RST_LO: phase_len = cfg.reset_cycles;
      PH_SETTLE:            phase_len = cfg.settle_cycles;
      default:              phase_len = cfg.pulse_cycles;
    endcase
  end

  // a length of zero behaves as one
  assign phase_lim  = (phase_len == '0) ? pacs_pkg::TimerBits'(1) : phase_len;
  assign timed_done = timer_cmd + pacs_pkg::TimerBits'(1) >= phase_lim;

  always_comb begin
    phase_next           = phase_cmd;
    phase_timer_next     = timed_done ? '0 : timer_cmd + pacs_pkg::TimerBits'(1);
    read_index_next      = index_cmd;
    remaining_count_next = remain_cmd;

    result_next                 = '0;
    result_next.convst_a_pin    = (phase_cmd != PH_CONV_A);
    result_next.convst_b_pin    = (phase_cmd != PH_CONV_B);
    result_next.read_select_pin = (phase_cmd != PH_RD_LOW);
    result_next.reset_pin       = (phase_cmd == PH_RST_HI);
    result_next.range_pin       = cfg.range_high;
    result_next.oversample_pins = cfg.oversample_ratio;

    unique case (phase_cmd)
      PH_RST_HI:  if (timed_done) phase_next = PH_RST_LO;
      PH_RST_LO:  if (timed_done) phase_next = PH_IDLE;
      PH_CONV_A:  if (timed_done) phase_next = PH_CONV_B;
      PH_CONV_B:  if (timed_done) phase_next = PH_SETTLE;
      PH_SETTLE:  if (timed_done) phase_next = PH_WAIT_BUSY;
      PH_PAUSE:   if (timed_done) phase_next = PH_RD_LOW;
      PH_WAIT_BUSY: begin
        phase_timer_next = timer_cmd;
        if (!busy_pin) begin
          phase_next       = PH_PAUSE;
          phase_timer_next = '0;
        end
      end
      PH_RD_LOW: begin
        if (timed_done) begin
          // bus word is taken at the end of the low strobe
          if (cfg.channel_mask[index_cmd]) begin
            result_next.sample_valid   = 1'b1;
            result_next.sample_value   = data_bus & SampleMask;
            result_next.sample_channel = index_cmd;
          end
          phase_next = PH_RD_HIGH;
        end
      end
      PH_RD_HIGH: begin
        if (timed_done) begin
          if (index_cmd >= LastIndex) begin
            read_index_next = '0;
            phase_next      = PH_IDLE;
            if (remain_cmd != '0) begin
              remaining_count_next = remain_cmd - pacs_pkg::CountBits'(1);
              result_next.run_done = (remain_cmd == pacs_pkg::CountBits'(1));
            end
          end else begin
            read_index_next = index_cmd + pacs_pkg::IndexBits'(1);
            phase_next      = PH_RD_LOW;
          end
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        phase_timer_next = '0;
      end
    endcase

    result_next.collecting   = (remaining_count_next != '0);
    result_next.overrun_flag = overrun_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      phase_timer     <= '0;
      read_index      <= '0;
      remaining_count <= '0;
      overrun_seen    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        phase_timer     <= phase_timer_next;
        read_index      <= read_index_next;
        remaining_count <= remaining_count_next;
        overrun_seen    <= overrun_seen_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload register, loads only with a new word
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/parallel_adc_capture_sequencer_top.sv
// parallel_adc_capture_sequencer_top: capture sequencer for an eight-channel parallel converter
// depends on pacs_pkg, pacs_if, pacs_cfg and pacs_seq
`default_nettype none

// Each input word is one clock of converter pin levels plus a command (none, start, timer
// tick); each accepted word yields exactly one result word of pin levels and an optional
// channel sample through a result register. A word is accepted every cycle while the result
// side keeps up; the result register lets a new word in while the previous result is being
// taken. Start loads the conversion count, clears overrun and pulses the converter reset;
// an idle tick with conversions left runs CONVST A, CONVST B, settle, busy wait, a pause
// and CHANNEL_COUNT read strobes, emitting the bus word of every enabled channel.
// Strobe, settle and reset lengths are counted in accepted words, set over the APB port.
module parallel_adc_capture_sequencer_top #(
  parameter int unsigned CHANNEL_COUNT = 8,
  parameter int unsigned SAMPLE_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  pacs_in_if.sink                            in_ch,
  pacs_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pacs_pkg::AddrBits-1:0] paddr,
  input  wire logic [pacs_pkg::DataBits-1:0] pwdata,
  output logic      [pacs_pkg::DataBits-1:0] prdata,
  output logic                               pready
);

  pacs_pkg::cfg_t    cfg;
  pacs_pkg::result_t result;
  logic              in_ready;
  logic              out_valid;

  pacs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pacs_seq #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ready),
    .command      (in_ch.command),
    .sample_count (in_ch.sample_count),
    .busy_pin     (in_ch.busy_pin),
    .data_bus     (in_ch.data_bus),
    .out_valid    (out_valid),
    .out_ready    (out_ch.ready),
    .result       (result)
  );

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.convst_a_pin    = result.convst_a_pin;
  assign out_ch.convst_b_pin    = result.convst_b_pin;
  assign out_ch.read_select_pin = result.read_select_pin;
  assign out_ch.reset_pin       = result.reset_pin;
  assign out_ch.range_pin       = result.range_pin;
  assign out_ch.oversample_pins = result.oversample_pins;
  assign out_ch.sample_valid    = result.sample_valid;
  assign out_ch.sample_value    = result.sample_value;
  assign out_ch.sample_channel  = result.sample_channel;
  assign out_ch.collecting      = result.collecting;
  assign out_ch.overrun_flag    = result.overrun_flag;
  assign out_ch.run_done        = result.run_done;

endmodule

`default_nettype wire
